// ===== rtl/core/mwns_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine generator for the note synth core.
// No dependencies; every other file of the core but mwns_fifo imports this package.
package mwns_pkg;

    localparam int unsigned VOLUME_W        = 15;
    localparam int unsigned SAMPLE_W        = 16;
    localparam int unsigned OPND_W          = 32;
    localparam int unsigned SAMPLES_W       = 22;
    localparam int unsigned DEF_SINE_DEPTH  = 256;
    localparam int unsigned DEF_PHASE_BITS  = 24;
    localparam int unsigned MID_DEPTH       = 4;
    localparam int unsigned OUT_DEPTH       = 8;
    localparam int unsigned OUT_CNT_W       = $clog2(OUT_DEPTH + 1);
    localparam int unsigned APB_ADDR_W      = 2;
    localparam int unsigned APB_DATA_W      = 32;

    localparam logic [VOLUME_W-1:0] VOLUME_RESET = 15'd16384;
    localparam logic [15:0]         LFSR_SEED    = 16'hACE1;
    localparam logic [15:0]         LFSR_TAPS    = 16'hB400;
    localparam logic [15:0]         NOISE_MOD    = 16'd10000;
    localparam logic [15:0]         NOISE_MID    = 16'd5000;
    localparam logic [15:0]         SINE_MID     = 16'd32767;

    // duration_ms * 44.1 as a multiply by ceil(2^29/10)*441, keep bits [50:29]
    localparam logic [34:0] DUR_SCALE   = 35'd23676007572;
    localparam int unsigned DUR_SHIFT   = 29;
    // divide by 5000 as a multiply by ceil(2^40/5000), exact below 2^28
    localparam logic [27:0] NOISE_RECIP = 28'd219902326;
    localparam int unsigned NOISE_SHIFT = 40;
    localparam logic [31:0] SINE_DIV    = 32'd65534;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register indexes of the configuration port
    localparam int unsigned REG_VOLUME = 0;

    typedef enum logic [2:0] {
        WAVE_SINE    = 3'd0,
        WAVE_SQUARE  = 3'd1,
        WAVE_SAW     = 3'd2,
        WAVE_SILENCE = 3'd3,
        WAVE_NOISE   = 3'd4
    } t_wave_code;

    typedef enum logic [2:0] {
        KIND_SINE,
        KIND_SQUARE,
        KIND_SAW,
        KIND_NOISE,
        KIND_SILENCE
    } t_kind;

    // One sample job handed from the front to the back
    typedef struct packed {
        t_kind               kind;
        logic                neg;
        logic [OPND_W-1:0]   operand;
        logic                mix;
        logic [SAMPLE_W-1:0] mix_in;
        logic                last;
    } t_work;

    localparam int unsigned WORK_W = $bits(t_work);
    localparam int unsigned RES_W  = SAMPLE_W + 1;

    // round(32767*sin(pi/2*m/2^lg)) from a Q30 odd polynomial; elaboration only
    function automatic logic [VOLUME_W-1:0] quarter_sine(input int unsigned m,
                                                         input int unsigned lg);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (64'(m) << 30) >> lg;
        x2 = (x * x) >> 30;
        t  = 64'd5026996 - ((x2 * 64'd172272) >> 30);
        t  = 64'd85569306 - ((x2 * t) >> 30);
        t  = 64'd693598672 - ((x2 * t) >> 30);
        t  = 64'd1686629713 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        v  = (s * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[VOLUME_W-1:0];
    endfunction

endpackage

// ===== rtl/core/multi_waveform_note_synth_core.sv =====
`timescale 1ns / 1ps
// Top level of the note synth core: configuration register, front end, back end and queues.
// Depends on mwns_pkg, mwns_fifo, mwns_front and mwns_back.

// Multi-waveform note synthesizer. Push a load command (cmd = 0) to latch a note:
// waveform (0 sine, 1 square, 2 saw, 3 silence, 4 noise; 5..7 act as silence), phase
// step in units of 2^-24 of a period per sample, square half period (0 treated as 1), length in ms and
// mix flag. Each following tick (cmd = 1) yields one 16-bit two's complement sample until
// duration_ms*441/10 samples are out; the final one has o_last set, and ticks beyond that
// give nothing. In mix mode the sample is added to that tick's i_mix_in, wrapping at 16
// bits (silence always gives zero). Loads give no result and do not reset the noise
// generator. One item is taken per clock while the job queue has room; a tick's result
// passes front end, table read, volume multiply and scaling, then leaves through an
// 8-entry result queue, so a full result side stalls the input only once the 4-entry
// job queue between front and back is also full. Peak level is set by the volume
// register (APB byte address 0, 15 bits, reset 16384); change it only while the core is idle.
module multi_waveform_note_synth_core #(
    parameter int unsigned SINE_TABLE_DEPTH = mwns_pkg::DEF_SINE_DEPTH,
    parameter int unsigned PHASE_BITS       = mwns_pkg::DEF_PHASE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input queue side
    input  logic                               push,
    output logic                               full,
    input  logic                               i_cmd,
    input  logic [2:0]                         i_waveform,
    input  logic [23:0]                        i_phase_step,
    input  logic [15:0]                        i_half_period,
    input  logic [15:0]                        i_duration_ms,
    input  logic                               i_mix_mode,
    input  logic [15:0]                        i_mix_in,
    // result queue side
    output logic                               empty,
    input  logic                               pop,
    output logic [mwns_pkg::SAMPLE_W-1:0]      o_sample,
    output logic                               o_last,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mwns_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mwns_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mwns_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import mwns_pkg::*;

    logic [VOLUME_W-1:0]  r_volume;
    logic                 w_cfg_write;
    logic                 w_accept;

    logic                 w_work_valid;
    t_work                w_work_in;
    logic [WORK_W-1:0]    w_mid_data;
    t_work                w_work_out;
    logic                 w_mid_empty;
    logic                 w_mid_full;
    logic [$clog2(MID_DEPTH+1)-1:0] w_mid_count;
    logic                 w_work_pop;

    logic                 w_res_valid;
    logic [SAMPLE_W-1:0]  w_res_sample;
    logic                 w_res_last;
    logic [RES_W-1:0]     w_out_data;
    logic                 w_out_full;
    logic [OUT_CNT_W-1:0] w_out_count;

    // Config: single register, every transfer lands on the volume register
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = APB_DATA_W'(r_volume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= VOLUME_RESET;
        end else if (w_cfg_write) begin
            r_volume <= pwdata[VOLUME_W-1:0];
        end
    end

    // An input transfer is taken whenever the job queue has room
    assign full     = w_mid_full;
    assign w_accept = push && !w_mid_full;

    mwns_front #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_cmd         (i_cmd),
        .i_waveform    (i_waveform),
        .i_phase_step  (i_phase_step),
        .i_half_period (i_half_period),
        .i_duration_ms (i_duration_ms),
        .i_mix_mode    (i_mix_mode),
        .i_mix_in      (i_mix_in),
        .o_work_valid  (w_work_valid),
        .o_work        (w_work_in)
    );

    // Job queue decouples note state from the arithmetic pipeline
    mwns_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_work_valid),
        .i_data  (w_work_in),
        .i_pop   (w_work_pop),
        .o_data  (w_mid_data),
        .o_full  (w_mid_full),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    assign w_work_out = t_work'(w_mid_data);

    mwns_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_avail (!w_mid_empty),
        .i_work       (w_work_out),
        .i_volume     (r_volume),
        .i_out_count  (w_out_count),
        .o_work_pop   (w_work_pop),
        .o_res_valid  (w_res_valid),
        .o_res_sample (w_res_sample),
        .o_res_last   (w_res_last)
    );

    // Result queue; the back end only issues work it has room for here
    mwns_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  ({w_res_sample, w_res_last}),
        .i_pop   (pop),
        .o_data  (w_out_data),
        .o_full  (w_out_full),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_sample = w_out_data[RES_W-1:1];
    assign o_last   = w_out_data[0];

    a_mid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_full |-> (w_mid_count == ($clog2(MID_DEPTH+1))'(MID_DEPTH)))
        else $error("job queue full flag and count disagree");

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !w_out_full)
        else $error("result queue overflow");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_LOAD)) |-> !w_work_valid)
        else $error("load transfer produced a job");

    a_cfg_word_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_write |-> (paddr == APB_ADDR_W'(4 * REG_VOLUME)))
        else $error("configuration write off the register word");
endmodule

// ===== rtl/core/mwns_fifo.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue with occupancy count.
// Uses nothing from the package; instantiated between front, back and the result port.
module mwns_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/core/mwns_front.sv =====
`timescale 1ns / 1ps
// Front end: latches notes, advances phase/square/noise state per tick and emits sample jobs.
// Depends on mwns_pkg.
module mwns_front #(
    parameter int unsigned SINE_TABLE_DEPTH = mwns_pkg::DEF_SINE_DEPTH,
    parameter int unsigned PHASE_BITS       = mwns_pkg::DEF_PHASE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_cmd,
    input  logic [2:0]            i_waveform,
    input  logic [23:0]           i_phase_step,
    input  logic [15:0]           i_half_period,
    input  logic [15:0]           i_duration_ms,
    input  logic                  i_mix_mode,
    input  logic [15:0]           i_mix_in,
    output logic                  o_work_valid,
    output mwns_pkg::t_work       o_work
);
    import mwns_pkg::*;

    localparam int unsigned LG      = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned ADDR_W  = LG + 1;
    localparam int unsigned STEP_UP = (PHASE_BITS >= 24) ? PHASE_BITS - 24 : 0;
    localparam int unsigned STEP_DN = (PHASE_BITS >= 24) ? 0 : 24 - PHASE_BITS;

    logic [PHASE_BITS-1:0] r_phase_acc, n_phase_acc;
    logic                  r_square_neg, n_square_neg;
    logic [15:0]           r_square_count, n_square_count;
    logic [SAMPLES_W-1:0]  r_samples_left, n_samples_left;
    logic [2:0]            r_wave_sel, n_wave_sel;
    logic                  r_mix_flag, n_mix_flag;
    logic [23:0]           r_step, n_step;
    logic [15:0]           r_half, n_half;
    logic [15:0]           r_lfsr, n_lfsr;

    logic [55:0]           w_step_wide;
    logic [PHASE_BITS-1:0] w_step;
    logic [PHASE_BITS-1:0] w_phase_sum;
    logic [PHASE_BITS-1:0] w_saw_mag;
    logic [LG-1:0]         w_idx;
    logic [ADDR_W-1:0]     w_r;
    logic [ADDR_W-1:0]     w_addr;
    logic [16:0]           w_cnt_inc;
    logic                  w_sq_neg;
    logic [15:0]           w_lfsr_n;
    logic [15:0]           w_mod;
    logic [15:0]           w_dist;
    logic [50:0]           w_dur_prod;

    always_comb begin
        w_step_wide = (56'(r_step) << STEP_UP) >> STEP_DN;
        w_step      = w_step_wide[PHASE_BITS-1:0];
        w_phase_sum = r_phase_acc + w_step;
        w_saw_mag   = w_phase_sum[PHASE_BITS-1] ? (~w_phase_sum + 1'b1) : w_phase_sum;

        // quadrant in the two top index bits, offset is the rest times four
        w_idx  = r_phase_acc[PHASE_BITS-1 -: LG];
        w_r    = {1'b0, w_idx[LG-3:0], 2'b00};
        w_addr = w_idx[LG-2] ? (ADDR_W'(SINE_TABLE_DEPTH) - w_r) : w_r;

        w_sq_neg  = (r_square_count == '0) ? !r_square_neg : r_square_neg;
        w_cnt_inc = 17'(r_square_count) + 17'd1;

        w_lfsr_n = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);
        priority if (w_lfsr_n >= 16'd60000) w_mod = w_lfsr_n - 16'd60000;
        else if (w_lfsr_n >= 16'd50000)     w_mod = w_lfsr_n - 16'd50000;
        else if (w_lfsr_n >= 16'd40000)     w_mod = w_lfsr_n - 16'd40000;
        else if (w_lfsr_n >= 16'd30000)     w_mod = w_lfsr_n - 16'd30000;
        else if (w_lfsr_n >= 16'd20000)     w_mod = w_lfsr_n - 16'd20000;
        else if (w_lfsr_n >= NOISE_MOD)     w_mod = w_lfsr_n - NOISE_MOD;
        else                                w_mod = w_lfsr_n;
        w_dist = (w_mod < NOISE_MID) ? (NOISE_MID - w_mod) : (w_mod - NOISE_MID);

        w_dur_prod = 51'(i_duration_ms) * 51'(DUR_SCALE);
    end

    always_comb begin
        n_phase_acc    = r_phase_acc;
        n_square_neg   = r_square_neg;
        n_square_count = r_square_count;
        n_samples_left = r_samples_left;
        n_wave_sel     = r_wave_sel;
        n_mix_flag     = r_mix_flag;
        n_step         = r_step;
        n_half         = r_half;
        n_lfsr         = r_lfsr;

        o_work_valid   = 1'b0;
        o_work.kind    = KIND_SILENCE;
        o_work.neg     = 1'b0;
        o_work.operand = '0;
        o_work.mix     = r_mix_flag;
        o_work.mix_in  = i_mix_in;
        o_work.last    = (r_samples_left == SAMPLES_W'(1));

        if (i_accept) begin
            if (i_cmd == CMD_LOAD) begin
                n_wave_sel     = i_waveform;
                n_step         = i_phase_step;
                n_half         = (i_half_period == '0) ? 16'd1 : i_half_period;
                n_samples_left = w_dur_prod[DUR_SHIFT +: SAMPLES_W];
                n_mix_flag     = i_mix_mode;
                n_phase_acc    = '0;
                n_square_neg   = 1'b0;
                n_square_count = '0;
            end else if (r_samples_left != '0) begin
                o_work_valid   = 1'b1;
                n_samples_left = r_samples_left - 1'b1;
                unique case (r_wave_sel)
                    WAVE_SINE: begin
                        o_work.kind    = KIND_SINE;
                        o_work.neg     = w_idx[LG-1];
                        o_work.operand = OPND_W'(w_addr);
                        n_phase_acc    = w_phase_sum;
                    end
                    WAVE_SQUARE: begin
                        o_work.kind    = KIND_SQUARE;
                        o_work.neg     = w_sq_neg;
                        o_work.operand = OPND_W'(1);
                        n_square_neg   = w_sq_neg;
                        n_square_count = (w_cnt_inc >= 17'(r_half)) ? '0 : w_cnt_inc[15:0];
                    end
                    WAVE_SAW: begin
                        o_work.kind    = KIND_SAW;
                        o_work.neg     = w_phase_sum[PHASE_BITS-1];
                        o_work.operand = OPND_W'(w_saw_mag);
                        n_phase_acc    = w_phase_sum;
                    end
                    WAVE_NOISE: begin
                        o_work.kind    = KIND_NOISE;
                        o_work.neg     = (w_mod < NOISE_MID);
                        o_work.operand = OPND_W'(w_dist);
                        n_lfsr         = w_lfsr_n;
                    end
                    default: begin
                        o_work.kind = KIND_SILENCE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc    <= '0;
            r_square_neg   <= 1'b0;
            r_square_count <= '0;
            r_samples_left <= '0;
            r_wave_sel     <= WAVE_SINE;
            r_mix_flag     <= 1'b0;
            r_step         <= '0;
            r_half         <= 16'd1;
            r_lfsr         <= LFSR_SEED;
        end else begin
            r_phase_acc    <= n_phase_acc;
            r_square_neg   <= n_square_neg;
            r_square_count <= n_square_count;
            r_samples_left <= n_samples_left;
            r_wave_sel     <= n_wave_sel;
            r_mix_flag     <= n_mix_flag;
            r_step         <= n_step;
            r_half         <= n_half;
            r_lfsr         <= n_lfsr;
        end
    end
endmodule

// ===== rtl/core/mwns_back.sv =====
`timescale 1ns / 1ps
// Back end: three-stage sample pipeline (table read, volume multiply, scale) plus sign and mix.
// Depends on mwns_pkg; takes jobs from the middle queue, writes the result queue.
module mwns_back #(
    parameter int unsigned SINE_TABLE_DEPTH = mwns_pkg::DEF_SINE_DEPTH,
    parameter int unsigned PHASE_BITS       = mwns_pkg::DEF_PHASE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_work_avail,
    input  mwns_pkg::t_work                   i_work,
    input  logic [mwns_pkg::VOLUME_W-1:0]     i_volume,
    input  logic [mwns_pkg::OUT_CNT_W-1:0]    i_out_count,
    output logic                              o_work_pop,
    output logic                              o_res_valid,
    output logic [mwns_pkg::SAMPLE_W-1:0]     o_res_sample,
    output logic                              o_res_last
);
    import mwns_pkg::*;

    localparam int unsigned LG     = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned ADDR_W = LG + 1;
    localparam int unsigned PROD_W = VOLUME_W + OPND_W;

    logic [VOLUME_W-1:0] w_rom [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        assign w_rom[g] = quarter_sine(g, LG);
    end

    // stage A: table read
    logic                r_a_valid;
    t_work               r_a_item;
    logic [VOLUME_W-1:0] r_a_mag;
    logic [ADDR_W-1:0]   w_rom_addr;
    // stage B: volume multiply
    logic                r_b_valid;
    t_work               r_b_item;
    logic [PROD_W-1:0]   r_b_prod;
    logic [15:0]         w_level;
    logic [OPND_W-1:0]   w_opnd;
    // stage C: scaled magnitude
    logic                r_c_valid;
    logic                r_c_neg;
    logic                r_c_mix;
    logic                r_c_silent;
    logic                r_c_last;
    logic [SAMPLE_W-1:0] r_c_mix_in;
    logic [VOLUME_W-1:0] r_c_mag;
    logic [VOLUME_W-1:0] w_scaled;
    logic [31:0]         w_sp;
    logic [31:0]         w_est;
    logic [31:0]         w_rem;
    logic [55:0]         w_noise_prod;
    logic [SAMPLE_W-1:0] w_signed;
    logic [OUT_CNT_W:0]  w_busy;

    // credit: everything in flight must fit in the result queue
    assign w_busy = (OUT_CNT_W+1)'(i_out_count) + (OUT_CNT_W+1)'(r_a_valid)
                  + (OUT_CNT_W+1)'(r_b_valid) + (OUT_CNT_W+1)'(r_c_valid);
    assign o_work_pop = i_work_avail && (w_busy < (OUT_CNT_W+1)'(OUT_DEPTH));
    assign w_rom_addr = (i_work.kind == KIND_SINE) ? i_work.operand[ADDR_W-1:0] : '0;

    always_comb begin
        w_level = r_a_item.neg ? (SINE_MID - 16'(r_a_mag)) : (SINE_MID + 16'(r_a_mag));
        unique case (r_a_item.kind)
            KIND_SINE: w_opnd = OPND_W'(w_level);
            default:   w_opnd = r_a_item.operand;
        endcase
    end

    always_comb begin
        // volume*level/65534: estimate low by at most one, then one correction
        w_sp         = r_b_prod[31:0];
        w_est        = (w_sp + (w_sp >> 15)) >> 16;
        w_rem        = w_sp - ((w_est << 16) - (w_est << 1));
        w_noise_prod = 56'(r_b_prod[27:0]) * 56'(NOISE_RECIP);
        unique case (r_b_item.kind)
            KIND_SINE:    w_scaled = (w_rem >= SINE_DIV) ? VOLUME_W'(w_est + 32'd1)
                                                         : w_est[VOLUME_W-1:0];
            KIND_SQUARE:  w_scaled = r_b_prod[VOLUME_W-1:0];
            KIND_SAW:     w_scaled = r_b_prod[PHASE_BITS-1 +: VOLUME_W];
            KIND_NOISE:   w_scaled = w_noise_prod[NOISE_SHIFT +: VOLUME_W];
            default:      w_scaled = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a_item   <= i_work;
        r_a_mag    <= w_rom[w_rom_addr];
        r_b_item   <= r_a_item;
        r_b_prod   <= PROD_W'(i_volume) * PROD_W'(w_opnd);
        r_c_mag    <= w_scaled;
        r_c_neg    <= r_b_item.neg && (r_b_item.kind != KIND_SINE)
                   && (r_b_item.kind != KIND_SILENCE);
        r_c_mix    <= r_b_item.mix && (r_b_item.kind != KIND_SILENCE);
        r_c_silent <= (r_b_item.kind == KIND_SILENCE);
        r_c_last   <= r_b_item.last;
        r_c_mix_in <= r_b_item.mix_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= o_work_pop;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    assign w_signed     = r_c_neg ? (SAMPLE_W'(0) - SAMPLE_W'(r_c_mag)) : SAMPLE_W'(r_c_mag);
    assign o_res_sample = r_c_mix ? (w_signed + r_c_mix_in) : w_signed;
    assign o_res_last   = r_c_last;
    assign o_res_valid  = r_c_valid;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy <= (OUT_CNT_W+1)'(OUT_DEPTH))
        else $error("result queue credit exceeded");

    a_room_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (i_out_count < OUT_CNT_W'(OUT_DEPTH)))
        else $error("result written into a full queue");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_work_pop |=> ##1 r_b_valid)
        else $error("job lost in the back pipeline");

    a_silence_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_silent) |-> (o_res_sample == '0))
        else $error("silent sample is not zero");
endmodule
